[rtl/core/qvn_pkg.sv]
`default_nettype none
package qvn_pkg;
	localparam int unsigned COMPONENT_BITS_DEF = 16;
	localparam int unsigned Q15_SHIFT = 15;
	localparam int unsigned UNIT_BITS = 17;
endpackage
`default_nettype wire

[rtl/core/q15_vector_normalizer.sv]
// q15_vector_normalizer: scales one signed 3-component vector to unit length
// in Q15. Pulse start with comp_x/y/z while busy is low; busy is always low,
// so a new vector may enter every cycle. The result appears on unit_x/y/z
// with done high for exactly one cycle, after 3 stages for magnitudes,
// squares and sum, CB+1 stages of the restoring square root (one root bit
// per stage, CB = COMPONENT_BITS), CB+Q15 stages of three restoring
// dividers (one quotient bit per stage) and one output register.
// The receiver cannot stall; results are never held. Zero vector gives zeros.
`default_nettype none
module q15_vector_normalizer #(
	parameter int unsigned COMPONENT_BITS = qvn_pkg::COMPONENT_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic signed [COMPONENT_BITS-1:0]   comp_x,
	input  wire logic signed [COMPONENT_BITS-1:0]   comp_y,
	input  wire logic signed [COMPONENT_BITS-1:0]   comp_z,
	output logic                                    done,
	output logic signed [qvn_pkg::UNIT_BITS-1:0]    unit_x,
	output logic signed [qvn_pkg::UNIT_BITS-1:0]    unit_y,
	output logic signed [qvn_pkg::UNIT_BITS-1:0]    unit_z
);
	import qvn_pkg::*;

	localparam int unsigned CB = COMPONENT_BITS;
	localparam int unsigned SB = 2*CB + 2;          // sum of three squares
	localparam int unsigned RB = SB/2;              // root bits
	localparam int unsigned NB = CB + Q15_SHIFT;    // dividend bits
	localparam int unsigned DL = NB;                // divider stages

	assign busy = 1'b0;

	// stage 1: magnitudes
	logic          v_s1;
	logic [CB-1:0] mag_s1 [3];
	logic          neg_s1 [3];
	// stage 2: squares
	logic          v_s2;
	logic [2*CB-1:0] sq_s2 [3];
	logic [CB-1:0] mag_s2 [3];
	logic          neg_s2 [3];
	// stage 3: sum
	logic          v_s3;
	logic [SB-1:0] sum_s3;
	logic [CB-1:0] mag_s3 [3];
	logic          neg_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else begin
			v_s1 <= start; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [CB-1:0] c [3];
		c[0] = comp_x; c[1] = comp_y; c[2] = comp_z;
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= c[i][CB-1];
			mag_s1[i] <= c[i][CB-1] ? CB'(-c[i]) : CB'(c[i]);
			sq_s2[i]  <= mag_s1[i] * mag_s1[i];
			mag_s2[i] <= mag_s1[i]; neg_s2[i] <= neg_s1[i];
			mag_s3[i] <= mag_s2[i]; neg_s3[i] <= neg_s2[i];
		end
		sum_s3 <= SB'(sq_s2[0]) + SB'(sq_s2[1]) + SB'(sq_s2[2]);
	end

	// square root: one root bit per stage, restoring, MSB first
	logic          rv   [RB+1];
	logic [SB-1:0] rrem [RB+1];
	logic [RB-1:0] rrt  [RB+1];
	logic [CB-1:0] rmag [RB+1][3];
	logic          rneg [RB+1][3];

	always_comb begin
		rv[0] = v_s3; rrem[0] = sum_s3; rrt[0] = '0;
		for (int i = 0; i < 3; i++) begin
			rmag[0][i] = mag_s3[i]; rneg[0][i] = neg_s3[i];
		end
	end

	for (genvar k = 0; k < RB; k++) begin : g_sqrt
		localparam int unsigned B = RB-1-k;
		logic [SB+1:0] trial;
		logic [SB+1:0] rem_w;
		always_comb begin
			// trial = (2*root + 2^B) << B = (root+2^B)^2 - root^2
			trial = (((SB+2)'(rrt[k]) << 1) | ((SB+2)'(1) << B)) << B;
			rem_w = (SB+2)'(rrem[k]);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv[k+1] <= 1'b0;
			else rv[k+1] <= rv[k];
		end
		always_ff @(posedge clk) begin
			if (rem_w >= trial) begin
				rrem[k+1] <= SB'(rem_w - trial);
				rrt[k+1]  <= rrt[k] | (RB'(1) << B);
			end else begin
				rrem[k+1] <= rrem[k];
				rrt[k+1]  <= rrt[k];
			end
			rmag[k+1] <= rmag[k]; rneg[k+1] <= rneg[k];
		end
	end

	// dividers: restoring, one quotient bit per stage; length <= 2^(CB+1)
	logic          dv   [DL+1];
	logic [RB-1:0] dlen [DL+1];
	logic [NB-1:0] dq   [DL+1][3];   // shifts dividend out, quotient in
	logic [RB:0]   drem [DL+1][3];
	logic          dneg [DL+1][3];

	always_comb begin
		dv[0] = rv[RB];
		dlen[0] = (rrt[RB] == '0) ? RB'(1) : rrt[RB];
		for (int i = 0; i < 3; i++) begin
			dq[0][i]   = {rmag[RB][i], Q15_SHIFT'(0)};
			drem[0][i] = '0;
			dneg[0][i] = rneg[RB][i];
		end
	end

	for (genvar k = 0; k < DL; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv[k+1] <= 1'b0;
			else dv[k+1] <= dv[k];
		end
		for (genvar i = 0; i < 3; i++) begin : g_lane
			logic [RB+1:0] sh;
			assign sh = {drem[k][i], dq[k][i][NB-1]};
			always_ff @(posedge clk) begin
				if (sh >= (RB+2)'(dlen[k])) begin
					drem[k+1][i] <= (RB+1)'(sh - (RB+2)'(dlen[k]));
					dq[k+1][i]   <= {dq[k][i][NB-2:0], 1'b1};
				end else begin
					drem[k+1][i] <= (RB+1)'(sh);
					dq[k+1][i]   <= {dq[k][i][NB-2:0], 1'b0};
				end
				dneg[k+1][i] <= dneg[k][i];
			end
		end
		always_ff @(posedge clk) dlen[k+1] <= dlen[k];
	end

	// output register
	logic [UNIT_BITS-1:0] u [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			u[i] = UNIT_BITS'(dq[DL][i]);
			if (dneg[DL][i]) u[i] = UNIT_BITS'(-u[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= dv[DL];
	end
	always_ff @(posedge clk) begin
		unit_x <= u[0]; unit_y <= u[1]; unit_z <= u[2];
	end
endmodule
`default_nettype wire

[rtl/core/qvn_checker.sv]
`default_nettype none
module qvn_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic busy,
	input wire logic done,
	input wire logic signed [16:0] unit_x,
	input wire logic signed [16:0] unit_y,
	input wire logic signed [16:0] unit_z
);
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy asserted");
	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (unit_x >= -17'sd32768 && unit_x <= 17'sd32768))
		else $error("unit_x range");
	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (unit_y >= -17'sd32768 && unit_y <= 17'sd32768))
		else $error("unit_y range");
	a_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (unit_z >= -17'sd32768 && unit_z <= 17'sd32768))
		else $error("unit_z range");
endmodule
bind q15_vector_normalizer qvn_checker u_qvn_checker (
	.clk(clk), .arst_n(arst_n), .busy(busy), .done(done),
	.unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z)
);
`default_nettype wire

[dv/tb_q15_vector_normalizer.sv]
`timescale 1ns / 100ps
`default_nettype none

// Testbench for q15_vector_normalizer.
// Vectors are sent at the falling edge; a transaction is accepted on the
// rising edge with start high and busy low. Each accepted vector gets its
// unit vector predicted right away and pushed on a queue. Every done pulse
// pops the oldest prediction and compares it field by field.
module tb_q15_vector_normalizer;
	import qvn_pkg::*;

	localparam int unsigned CB = COMPONENT_BITS_DEF;
	// pipeline depth from the block's own description, plus slack
	localparam int unsigned LATENCY = 3 + (2*CB+2)/2 + 1 + CB + Q15_SHIFT + 1;
	localparam longint unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [UNIT_BITS-1:0] ux;
		logic signed [UNIT_BITS-1:0] uy;
		logic signed [UNIT_BITS-1:0] uz;
	} unit_vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [CB-1:0] comp_x = '0;
	logic signed [CB-1:0] comp_y = '0;
	logic signed [CB-1:0] comp_z = '0;
	logic done;
	logic signed [UNIT_BITS-1:0] unit_x, unit_y, unit_z;

	unit_vec_t pending_units[$];
	int errors = 0;
	longint unsigned cycles = 0;
	bit no_gaps = 1'b0;

	always #1 clk = ~clk;

	q15_vector_normalizer #(.COMPONENT_BITS(CB)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z),
		.done(done), .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z)
	);

	// floor square root, bit by bit
	function automatic longint unsigned isqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic unit_vec_t normalize(logic signed [CB-1:0] x,
			logic signed [CB-1:0] y, logic signed [CB-1:0] z);
		longint signed cx, cy, cz;
		longint unsigned len;
		unit_vec_t u;
		cx = x; cy = y; cz = z;
		len = isqrt(longint'(cx*cx + cy*cy + cz*cz));
		if (len == 0) len = 1;
		// signed divide in SV truncates toward zero
		u.ux = UNIT_BITS'((cx <<< Q15_SHIFT) / longint'(len));
		u.uy = UNIT_BITS'((cy <<< Q15_SHIFT) / longint'(len));
		u.uz = UNIT_BITS'((cz <<< Q15_SHIFT) / longint'(len));
		return u;
	endfunction

	// result checker; done is never stalled, so sample every rising edge
	always @(posedge clk) begin
		unit_vec_t exp_u;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[q15_vector_normalizer] ERROR");
			$finish;
		end
		if (arst_n && done) begin
			if (pending_units.size() == 0) begin
				$display("%0t: unexpected result %0d %0d %0d", $time,
					unit_x, unit_y, unit_z);
				errors++;
			end else begin
				exp_u = pending_units.pop_front();
				if (unit_x !== exp_u.ux) begin
					$display("%0t: unit_x exp %0d got %0d", $time, exp_u.ux, unit_x);
					errors++;
				end
				if (unit_y !== exp_u.uy) begin
					$display("%0t: unit_y exp %0d got %0d", $time, exp_u.uy, unit_y);
					errors++;
				end
				if (unit_z !== exp_u.uz) begin
					$display("%0t: unit_z exp %0d got %0d", $time, exp_u.uz, unit_z);
					errors++;
				end
			end
		end
	end

	// one transaction; start stays high across back-to-back vectors
	task automatic send_vector(input logic signed [CB-1:0] x,
			input logic signed [CB-1:0] y, input logic signed [CB-1:0] z);
		int gap;
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		comp_x <= x; comp_y <= y; comp_z <= z;
		do @(posedge clk); while (busy);
		pending_units.push_back(normalize(x, y, z));
		@(negedge clk);
	endtask

	function automatic logic signed [CB-1:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return CB'($urandom_range(0, 15)) - CB'(8);
			1: return {1'b1, {(CB-1){1'b0}}};
			2: return {1'b0, {(CB-1){1'b1}}};
			default: return CB'($urandom);
		endcase
	endfunction

	task automatic test_extremes();
		logic signed [CB-1:0] mx, mn;
		mx = {1'b0, {(CB-1){1'b1}}};
		mn = {1'b1, {(CB-1){1'b0}}};
		send_vector(CB'(0), CB'(0), CB'(0));        // zero vector, length forced to 1
		send_vector(CB'(1), CB'(1), CB'(1));        // outputs hit +32768
		send_vector(CB'(-1), CB'(-1), CB'(-1));
		send_vector(mx, mx, mx);
		send_vector(mn, mn, mn);
		send_vector(mn, CB'(0), CB'(0));
		send_vector(CB'(0), mx, CB'(0));
		send_vector(CB'(0), CB'(0), mn);
		send_vector(CB'(1), CB'(0), CB'(0));
		send_vector(CB'(0), CB'(-1), CB'(0));
		send_vector(mx, mn, CB'(0));
		send_vector(mn, mx, CB'(-1));
		send_vector(CB'(3), CB'(4), CB'(0));
		send_vector(CB'(-2), CB'(1), CB'(2));
		send_vector(CB'(16'sh5A82), CB'(16'shA57E), CB'(0));
	endtask

	task automatic test_random(input int count);
		repeat (count) send_vector(rand_comp(), rand_comp(), rand_comp());
	endtask

	// wrist-up rotation matrix columns: x in 0..23170, z in -2000..2000
	task automatic test_rotation_columns(input int count);
		int a;
		repeat (count) begin
			a = $urandom_range(0, 23170);
			send_vector(CB'(a), CB'($urandom_range(0, 32767 - a)) - CB'(a/2),
				CB'($urandom_range(0, 4000)) - CB'(2000));
		end
	endtask

	task automatic drain();
		int guard;
		start <= 1'b0;
		guard = 0;
		while (pending_units.size() != 0 && guard < 10 * LATENCY) begin
			@(negedge clk);
			guard++;
		end
		repeat (LATENCY) @(negedge clk);
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_extremes();
		test_random(900);
		test_rotation_columns(600);
		no_gaps = 1'b1;
		test_random(300);
		drain();
		if (errors == 0 && pending_units.size() == 0) begin
			$display("[q15_vector_normalizer] OK");
		end else begin
			$display("[q15_vector_normalizer] ERROR");
		end
		$finish;
	end
endmodule

`default_nettype wire
